// ----- hw/rtl/swa_pkg.sv -----
`timescale 1ns / 1ps

package swa_pkg;

    // default window length in samples
    localparam int WINDOW_DEFAULT = 64;

    // field widths
    localparam int SAMPLE_W    = 17;
    localparam int AVG_W       = 17;
    localparam int COUNT_OUT_W = 7;

    // Q1.16 constants
    localparam logic [SAMPLE_W-1:0] Q16_ONE  = SAMPLE_W'(65536);
    localparam logic [AVG_W-1:0]    Q16_HALF = AVG_W'(32768);

    // opcodes
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [SAMPLE_W-1:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic [AVG_W-1:0]       window_average;
        logic [COUNT_OUT_W-1:0] sample_count;
    } t_out_item;

endpackage

// ----- hw/rtl/swa_ram.sv -----
`timescale 1ns / 1ps

// simple dual-port RAM, one write port, one registered read port
module swa_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/swa_div.sv -----
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
// quotient is known to fit AVG_W bits, so the upper dividend bits seed the remainder
module swa_div #(
    parameter int SUM_W = 23,
    parameter int CNT_W = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [SUM_W-1:0]           i_dividend,
    input  logic [CNT_W-1:0]           i_divisor,
    output logic                       o_done,
    output logic [swa_pkg::AVG_W-1:0]  o_quot
);

    localparam int QW     = swa_pkg::AVG_W;
    localparam int STEP_W = $clog2(QW);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_den;
    logic [QW-1:0]     r_q;

    logic [CNT_W:0]    shifted;
    logic [CNT_W+1:0]  diff;
    logic              take;

    // trial subtract of divisor from shifted remainder
    always_comb begin
        shifted = {r_rem, r_q[QW-1]};
        diff    = {1'b0, shifted} - {2'b00, r_den};
        take    = ~diff[CNT_W+1];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_step == '0)) begin
            r_busy <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= STEP_W'(QW - 1);
            r_rem  <= CNT_W'(i_dividend[SUM_W-1:QW]);
            r_q    <= i_dividend[QW-1:0];
            r_den  <= i_divisor;
        end else if (r_busy) begin
            r_step <= r_step - STEP_W'(1);
            r_rem  <= take ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            r_q    <= {r_q[QW-2:0], take};
        end
    end

    assign o_done = r_busy && (r_step == '0);
    assign o_quot = r_q;

endmodule

// ----- hw/rtl/sliding_window_average_unit.sv -----
`timescale 1ns / 1ps

// Sliding-window average of unsigned Q1.16 samples.
// Input channel (i_in_valid / o_in_ready / i_in_data): opcode RECORD stores a
// sample (values above 1.0 saturate to 1.0) and drops the oldest one once the
// window is full; opcode CLEAR empties the window. Each request returns one
// result on the output channel (o_out_valid / i_out_ready / o_out_data): the
// truncated average of the held samples, or 0.5 when empty, and the count.
// One request is worked on at a time; o_in_ready is low while busy.
// Record: after acceptance the oldest entry is read from the ring, the sum
// and count are updated, the 17-step restoring divider forms the average,
// and the result is written to the output register.
// Clear: after acceptance the result is written to the output register.
// The result sits in an output register; a stalled receiver holds it, and the
// block finishes the next request and waits with its result until the
// register frees up.
// Reset clears pointer, count, sum and the output valid. Ring contents are
// not cleared; an entry is read only after it has been written.
module sliding_window_average_unit #(
    parameter int WINDOW = swa_pkg::WINDOW_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  swa_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output swa_pkg::t_out_item o_out_data
);

    localparam int PW    = $clog2(WINDOW);
    localparam int CW    = $clog2(WINDOW + 1);
    localparam int SUM_W = PW + swa_pkg::SAMPLE_W;
    localparam int SW    = swa_pkg::SAMPLE_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_UPDATE = 4'b0010,
        S_DIV    = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    logic [SW-1:0]            r_sample, n_sample;
    logic [PW-1:0]            r_pos, n_pos;
    logic [CW-1:0]            r_count, n_count;
    logic [SUM_W-1:0]         r_sum, n_sum;
    logic                     r_out_valid, n_out_valid;
    swa_pkg::t_out_item       r_out, n_out;

    logic [PW-1:0]            nxt_pos;
    logic                     full;
    logic                     accept;
    logic                     out_free;
    logic                     ram_we;
    logic [SW-1:0]            old_sample;
    logic                     div_start;
    logic                     div_done;
    logic [swa_pkg::AVG_W-1:0] div_quot;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;
    assign nxt_pos  = (r_pos == PW'(WINDOW - 1)) ? '0 : r_pos + PW'(1);
    assign full     = (r_count == CW'(WINDOW));

    // sample ring
    swa_ram #(
        .WIDTH (SW),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (nxt_pos),
        .i_wdata (r_sample),
        .i_raddr (nxt_pos),
        .o_rdata (old_sample)
    );

    // divider
    swa_div #(
        .SUM_W (SUM_W),
        .CNT_W (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sum),
        .i_divisor  (n_count),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_sample    = r_sample;
        n_pos       = r_pos;
        n_count     = r_count;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        div_start   = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_data.opcode == swa_pkg::OP_CLEAR) begin
                        n_pos   = '0;
                        n_count = '0;
                        n_sum   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_sample = (i_in_data.sample_value > swa_pkg::Q16_ONE) ?
                                   swa_pkg::Q16_ONE : i_in_data.sample_value;
                        n_state  = S_UPDATE;
                    end
                end
            end
            S_UPDATE: begin
                // old entry read at nxt_pos arrived this cycle
                n_sum     = (full ? r_sum - SUM_W'(old_sample) : r_sum) + SUM_W'(r_sample);
                n_count   = full ? r_count : r_count + CW'(1);
                n_pos     = nxt_pos;
                ram_we    = 1'b1;
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out.window_average = (r_count == '0) ? swa_pkg::Q16_HALF : div_quot;
                    n_out.sample_count   = swa_pkg::COUNT_OUT_W'(r_count);
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_out    <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hw/rtl/swa_check.sv -----
`timescale 1ns / 1ps

// port-level checks for the sliding-window average unit
module swa_check #(
    parameter int WINDOW = swa_pkg::WINDOW_DEFAULT
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input swa_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input swa_pkg::t_out_item o_out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after accepting a request");

    // average never above 1.0
    a_avg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.window_average <= swa_pkg::Q16_ONE)
        else $error("average above 1.0");

    // count within window
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (WINDOW >= 128) ||
                        (int'(o_out_data.sample_count) <= WINDOW))
        else $error("count beyond window");

    // empty window reports one half
    a_empty_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.sample_count == '0) |->
            (WINDOW >= 128) || (o_out_data.window_average == swa_pkg::Q16_HALF))
        else $error("empty window average not one half");

endmodule

bind sliding_window_average_unit swa_check #(
    .WINDOW (WINDOW)
) u_swa_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import swa_pkg::*;

    localparam int WIN         = WINDOW_DEFAULT;
    localparam int POS_W       = $clog2(WIN);
    localparam int SUM_W       = 23;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 25;
    localparam int LONG_HOLD   = 300;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_data;

    sliding_window_average_unit #(
        .WINDOW(WIN)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    // shadow copy of the window state
    logic [SAMPLE_W-1:0] ring_mirror [WIN];
    logic [POS_W-1:0]    head_mirror;
    logic [6:0]          fill_mirror;
    logic [SUM_W-1:0]    sum_mirror;

    // averages still owed by the block, oldest first
    t_out_item avg_pending_q [$];

    int  error_count;
    int  cycle_count;
    int  request_count;
    int  record_count;
    int  clear_count;
    int  saturate_count;
    int  overwrite_count;
    int  results_seen;
    int  hold_off_cycles;
    bit  send_idle_on;
    bit  recv_idle_on;

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d averages still pending", $time,
                     avg_pending_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int draw_gap(bit enabled);
        return enabled ? int'($urandom_range(0, 15)) : 0;
    endfunction

    // apply one request to the shadow state and return the average it yields
    function automatic t_out_item predict_window_avg(t_in_item req);
        t_out_item           res;
        logic [SAMPLE_W-1:0] v;
        logic [SAMPLE_W-1:0] old;
        logic [POS_W-1:0]    nxt;
        logic [SUM_W-1:0]    quot;
        if (req.opcode == OP_CLEAR) begin
            head_mirror = '0;
            fill_mirror = '0;
            sum_mirror  = '0;
        end else begin
            v = (req.sample_value > Q16_ONE) ? Q16_ONE : req.sample_value;
            nxt = (head_mirror == POS_W'(WIN - 1)) ? '0 : head_mirror + POS_W'(1);
            if (fill_mirror >= 7'(WIN)) begin
                old = ring_mirror[nxt];
                sum_mirror = (sum_mirror >= SUM_W'(old)) ? sum_mirror - SUM_W'(old) : '0;
            end else begin
                fill_mirror = fill_mirror + 7'(1);
            end
            head_mirror      = nxt;
            ring_mirror[nxt] = v;
            sum_mirror       = sum_mirror + SUM_W'(v);
        end
        if (fill_mirror == '0) begin
            res.window_average = Q16_HALF;
        end else begin
            quot = sum_mirror / SUM_W'(fill_mirror);
            res.window_average = quot[AVG_W-1:0];
        end
        res.sample_count = fill_mirror;
        return res;
    endfunction

    // offer one request and hold it until the block takes it
    task automatic send_request(input logic op, input logic [SAMPLE_W-1:0] value);
        int        gap;
        t_out_item pred;
        gap = draw_gap(send_idle_on);
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_data.opcode       = op;
        in_data.sample_value = value;
        in_valid             = 1'b1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        if (op == OP_CLEAR) begin
            clear_count++;
        end else begin
            record_count++;
            if (value > Q16_ONE) saturate_count++;
            if (fill_mirror >= 7'(WIN)) overwrite_count++;
        end
        request_count++;
        pred = predict_window_avg(in_data);
        avg_pending_q.insert(avg_pending_q.size(), pred);
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        results_seen++;
        if (avg_pending_q.size() == 0) begin
            $display("%0t: result with nothing pending: avg %0d count %0d", $time,
                     got.window_average, got.sample_count);
            error_count++;
        end else begin
            want = avg_pending_q.pop_front();
            if (got.window_average !== want.window_average) begin
                $display("%0t: window_average mismatch: expected %0d actual %0d", $time,
                         want.window_average, got.window_average);
                error_count++;
            end
            if (got.sample_count !== want.sample_count) begin
                $display("%0t: sample_count mismatch: expected %0d actual %0d", $time,
                         want.sample_count, got.sample_count);
                error_count++;
            end
        end
    endtask

    // receiver: checks results at the rising edge, drives ready at the falling edge
    initial begin : result_receiver
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_valid && out_ready) begin
                check_result(out_data);
                stall = draw_gap(recv_idle_on);
            end
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                out_ready = 1'b0;
                hold_off_cycles--;
            end else if (stall > 0) begin
                out_ready = 1'b0;
                stall--;
            end else begin
                out_ready = 1'b1;
            end
        end
    end

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return Q16_ONE;
            2: return SAMPLE_W'($urandom_range(65537, 131071));
            default: return SAMPLE_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // empty window: clear on reset state, then the first records and a clear
    task automatic test_empty_window();
        send_request(OP_CLEAR, '0);
        send_request(OP_CLEAR, '1);
        send_request(OP_RECORD, '0);
        send_request(OP_RECORD, Q16_ONE);
        send_request(OP_CLEAR, 17'h0AAAA);
    endtask

    // extremes of the sample field, including values that saturate
    task automatic test_sample_extremes();
        send_request(OP_RECORD, 17'd1);
        send_request(OP_RECORD, 17'd65535);
        send_request(OP_RECORD, 17'd65537);
        send_request(OP_RECORD, '1);
        send_request(OP_RECORD, 17'h15555);
        send_request(OP_RECORD, 17'h0AAAA);
    endtask

    // clear in the middle of a partly filled window, then refill
    task automatic test_clear_mid_window();
        send_request(OP_RECORD, 17'd40000);
        send_request(OP_CLEAR, 17'd12345);
        send_request(OP_RECORD, 17'd3);
        send_request(OP_RECORD, 17'd4);
        send_request(OP_RECORD, 17'd65536);
    endtask

    // full window of saturated samples: largest sum, average of one, wrap
    task automatic test_full_scale_window();
        send_request(OP_CLEAR, '0);
        repeat (WIN + 8) send_request(OP_RECORD, SAMPLE_W'($urandom_range(65536, 131071)));
        repeat (WIN + 4) send_request(OP_RECORD, '0);
    endtask

    // long receiver stall while requests keep coming
    task automatic test_output_backpressure();
        send_idle_on    = 1'b0;
        hold_off_cycles = LONG_HOLD;
        repeat (20) send_request(OP_RECORD, random_sample());
        send_request(OP_CLEAR, random_sample());
        send_idle_on = 1'b1;
    endtask

    // bursts of records ending in a clear, with stray clears as noise
    task automatic test_random_bursts(input int target);
        int burst;
        while (request_count < target) begin
            send_idle_on = ($urandom_range(0, 2) != 0);
            recv_idle_on = ($urandom_range(0, 2) != 0);
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20)
                                                : $urandom_range(40, 160);
            // keep the total close to the target
            if (burst > target - request_count) burst = target - request_count;
            repeat (burst) begin
                if ($urandom_range(0, 59) == 0)
                    send_request(OP_CLEAR, SAMPLE_W'($urandom_range(0, 131071)));
                else
                    send_request(OP_RECORD, random_sample());
            end
            send_request(OP_CLEAR, SAMPLE_W'($urandom_range(0, 131071)));
        end
    endtask

    initial begin
        ring_mirror     = '{default: '0};
        head_mirror     = '0;
        fill_mirror     = '0;
        sum_mirror      = '0;
        error_count     = 0;
        cycle_count     = 0;
        request_count   = 0;
        record_count    = 0;
        clear_count     = 0;
        saturate_count  = 0;
        overwrite_count = 0;
        results_seen    = 0;
        hold_off_cycles = 0;
        send_idle_on    = 1'b1;
        recv_idle_on    = 1'b1;
        in_valid        = 1'b0;
        in_data         = '0;
        out_ready       = 1'b0;
        i_rst_n         = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_window();
        test_sample_extremes();
        test_clear_mid_window();
        test_full_scale_window();
        test_output_backpressure();
        test_random_bursts(1050);

        // drain
        @(negedge i_clk);
        in_valid = 1'b0;
        while (avg_pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d requests: %0d records (%0d saturated, %0d overwrote), %0d clears",
                 request_count, record_count, saturate_count, overwrite_count, clear_count);
        $display("Checked %0d averages, %0d errors", results_seen, error_count);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
